@@ rtl/spm_pkg.sv @@
// spm_pkg: types and constants for the single-precision multiplier.
// No dependencies.
package spm_pkg;

  typedef enum logic [2:0] {
    CASE_NORMAL = 3'd0,
    CASE_NAN    = 3'd1,
    CASE_INF    = 3'd2,
    CASE_ZERO   = 3'd3,
    CASE_OVF    = 3'd4,
    CASE_UNF    = 3'd5
  } case_e;

  localparam logic [31:0] QNAN    = 32'h7fc0_0000;
  localparam logic [31:0] POS_INF = 32'h7f80_0000;
  localparam logic [9:0]  BIAS    = 10'd127;

  // Stage 1 -> stage 2: decoded operands
  typedef struct packed {
    logic        special;
    case_e       code;
    logic        sign;
    logic [9:0]  exp;    // ea + eb - 127, signed
    logic [23:0] ma;
    logic [23:0] mb;
  } dec_t;

  // Stage 2 -> stage 3: raw product
  typedef struct packed {
    logic        special;
    case_e       code;
    logic        sign;
    logic [9:0]  exp;
    logic [47:0] prod;
  } mul_t;

  // Result payload
  typedef struct packed {
    logic [31:0] product;
    case_e       code;
  } res_t;

endpackage

@@ rtl/spm_if.sv @@
// spm_if: valid/ready channel interface with generic payload.
// Depends on nothing.
interface spm_if #(
  parameter int Width = 64
) ();
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/single_precision_multiplier.sv @@
// single_precision_multiplier: three-stage pipelined float32 multiply.
// Depends on spm_pkg, spm_if, spm_decode, spm_pack.
//
// Usage:
//   in_if  (sink):   data = {operand_a, operand_b}, one request per cycle.
//   out_if (source): data = {product, case_code}.
// Stage 1 decodes special cases and sums exponents, stage 2 forms the
// 24x24 significand product, stage 3 normalizes, truncates and packs.
// Three register stages: dec_q, mul_q and res_q. Throughput: one request
// per cycle while in_if.ready is high.
// Reset clears all stage valid bits; payload registers are not reset.
// When the receiver stalls, each stage holds while the one after it is
// full and held; a bubble lets an earlier stage advance, so ready stays
// high until all three stages are full. Nothing is lost or repeated.
// case_code: 0 normal, 1 NaN, 2 infinite input, 3 zero or subnormal input,
// 4 overflow, 5 underflow.
module single_precision_multiplier import spm_pkg::*; (
  input logic  clk_i,
  input logic  rst_ni,
  spm_if.sink   in_if,
  spm_if.source out_if
);
  dec_t dec_d, dec_q;
  mul_t mul_d, mul_q;
  res_t res_d, res_q;
  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;

  // Stall chain
  assign en3         = !v3_q || out_if.ready;
  assign en2         = !v2_q || en3;
  assign en1         = !v1_q || en2;
  assign in_if.ready = en1;

  spm_decode u_dec (
    .operand_a_i(in_if.data[63:32]),
    .operand_b_i(in_if.data[31:0]),
    .dec_o      (dec_d)
  );

  // Significand product
  always_comb begin
    mul_d.special = dec_q.special;
    mul_d.code    = dec_q.code;
    mul_d.sign    = dec_q.sign;
    mul_d.exp     = dec_q.exp;
    mul_d.prod    = {24'd0, dec_q.ma} * {24'd0, dec_q.mb};
  end

  spm_pack u_pack (
    .mul_i(mul_q),
    .res_o(res_d)
  );

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_if.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (en1 && in_if.valid) dec_q <= dec_d;
    if (en2 && v1_q)        mul_q <= mul_d;
    if (en3 && v2_q)        res_q <= res_d;
  end

  assign out_if.valid = v3_q;
  assign out_if.data  = {res_q.product, res_q.code};

`ifndef ASSERT_OFF
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid && $stable(out_if.data))
    else $error("output changed under stall");
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_if.ready |-> v1_q && v2_q && v3_q && !out_if.ready)
    else $error("ready low with a free stage");
  a_code_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> out_if.data[2:0] <= CASE_UNF)
    else $error("bad case code");
  a_nan_val: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.data[2:0] == CASE_NAN |-> out_if.data[34:3] == QNAN)
    else $error("NaN result mismatch");
`endif
endmodule

@@ rtl/spm_decode.sv @@
// spm_decode: special-case detection, sign and exponent sum.
// Depends on spm_pkg.
module spm_decode import spm_pkg::*; (
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  output dec_t        dec_o
);
  logic [7:0] ea, eb;
  logic       nan_a, nan_b, inf_a, inf_b;

  assign ea    = operand_a_i[30:23];
  assign eb    = operand_b_i[30:23];
  assign nan_a = (ea == 8'hff) && (operand_a_i[22:0] != '0);
  assign nan_b = (eb == 8'hff) && (operand_b_i[22:0] != '0);
  assign inf_a = (ea == 8'hff) && (operand_a_i[22:0] == '0);
  assign inf_b = (eb == 8'hff) && (operand_b_i[22:0] == '0);

  always_comb begin
    dec_o.special = 1'b1;
    if (nan_a || nan_b) begin
      dec_o.code = CASE_NAN;
    end else if (inf_a || inf_b) begin
      dec_o.code = CASE_INF;
    end else if (ea == '0 || eb == '0) begin
      dec_o.code = CASE_ZERO;
    end else begin
      dec_o.code    = CASE_NORMAL;
      dec_o.special = 1'b0;
    end
    dec_o.sign = operand_a_i[31] ^ operand_b_i[31];
    dec_o.exp  = {2'b00, ea} + {2'b00, eb} - BIAS;
    dec_o.ma   = {1'b1, operand_a_i[22:0]};
    dec_o.mb   = {1'b1, operand_b_i[22:0]};
  end
endmodule

@@ rtl/spm_pack.sv @@
// spm_pack: normalize by one place, truncate, detect over/underflow.
// Depends on spm_pkg.
module spm_pack import spm_pkg::*; (
  input  mul_t mul_i,
  output res_t res_o
);
  logic [9:0]  e;
  logic [22:0] frac;

  always_comb begin
    if (mul_i.prod[47]) begin
      frac = mul_i.prod[46:24];
      e    = mul_i.exp + 10'd1;
    end else begin
      frac = mul_i.prod[45:23];
      e    = mul_i.exp;
    end
    if (mul_i.special) begin
      res_o.code = mul_i.code;
      case (mul_i.code)
        CASE_NAN: res_o.product = QNAN;
        CASE_INF: res_o.product = POS_INF;
        default:  res_o.product = '0;
      endcase
    end else if (!e[9] && e >= 10'd255) begin
      res_o.code    = CASE_OVF;
      res_o.product = {mul_i.sign, POS_INF[30:0]};
    end else if (e[9] || e == '0) begin
      res_o.code    = CASE_UNF;
      res_o.product = '0;
    end else begin
      res_o.code    = CASE_NORMAL;
      res_o.product = {mul_i.sign, e[7:0], frac};
    end
  end
endmodule

@@ tb/single_precision_multiplier_test.sv @@
// Testbench for the three-stage single-precision multiplier.
// Depends on spm_pkg, spm_if and single_precision_multiplier; checks every
// product and case code against a behavioral predictor.
module single_precision_multiplier_test;
  timeunit 1ns;
  timeprecision 1ps;
  import spm_pkg::*;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
  } operands_t;

  localparam int NumItems = 1300;

  logic clk_i;
  logic rst_ni;

  spm_if #(.Width(64)) in_if ();
  spm_if #(.Width(35)) out_if ();

  single_precision_multiplier dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (in_if.sink),
    .out_if(out_if.source)
  );

  operands_t pending_q[$];
  res_t      expected_q[$];
  int        mismatches = 0;
  int        issued;
  int        accepted;
  int        received;
  bit        quiet_phase = 1'b0;
  bit        hold_sender = 1'b0;
  bit        hold_done;
  int        rx_hold_cycles;
  int        tx_gap;
  int        rx_gap;

  // Clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Behavioral float multiply with truncation
  function automatic res_t fmul_predict(logic [31:0] a, logic [31:0] b);
    res_t r;
    logic [7:0] ea, eb;
    logic [22:0] fa, fb;
    logic [47:0] p;
    logic [22:0] frac;
    int e;
    ea = a[30:23];
    eb = b[30:23];
    fa = a[22:0];
    fb = b[22:0];
    if ((ea == 8'hff && fa != 0) || (eb == 8'hff && fb != 0)) begin
      r.product = QNAN;
      r.code = CASE_NAN;
    end else if (ea == 8'hff || eb == 8'hff) begin
      r.product = POS_INF;
      r.code = CASE_INF;
    end else if (ea == 0 || eb == 0) begin
      r.product = 32'h0;
      r.code = CASE_ZERO;
    end else begin
      e = int'(ea) + int'(eb) - 127;
      p = {24'h0, 1'b1, fa} * {24'h0, 1'b1, fb};
      if (p[47]) begin
        frac = p[46:24];
        e++;
      end else begin
        frac = p[45:23];
      end
      if (e >= 255) begin
        r.product = {a[31] ^ b[31], 31'h7f80_0000};
        r.code = CASE_OVF;
      end else if (e <= 0) begin
        r.product = 32'h0;
        r.code = CASE_UNF;
      end else begin
        r.product = {a[31] ^ b[31], e[7:0], frac};
        r.code = CASE_NORMAL;
      end
    end
    return r;
  endfunction

  // Random normal operand with chosen exponent range
  function automatic logic [31:0] rand_normal(int lo, int hi);
    return {$urandom_range(1, 0) == 1, 8'($urandom_range(hi, lo)),
            23'($urandom)};
  endfunction

  function automatic logic [31:0] rand_operand();
    int kind;
    kind = $urandom_range(99, 0);
    if (kind < 60) return rand_normal(100, 154);
    if (kind < 75) return rand_normal(1, 254);
    if (kind < 80) return {$urandom_range(1, 0) == 1, 8'hff, 23'($urandom)};
    if (kind < 84) return {$urandom_range(1, 0) == 1, 8'hff, 23'h0};
    if (kind < 90) return {$urandom_range(1, 0) == 1, 8'h00,
                           ($urandom_range(1, 0) == 1) ? 23'($urandom) : 23'h0};
    return $urandom;
  endfunction

  // Driver: inputs change on the falling edge
  always @(negedge clk_i or negedge rst_ni) begin : drv
    operands_t op;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.data  <= '0;
      tx_gap      <= 0;
      issued      <= 0;
    end else if (!in_if.valid || accepted == issued) begin
      // previous request taken, or none on the bus
      if (tx_gap > 0) begin
        in_if.valid <= 1'b0;
        tx_gap      <= tx_gap - 1;
      end else if (hold_sender || pending_q.size() == 0) begin
        in_if.valid <= 1'b0;
      end else begin
        op = pending_q.pop_front();
        in_if.valid <= 1'b1;
        in_if.data  <= {op.a, op.b};
        issued      <= issued + 1;
        if (!quiet_phase && $urandom_range(3, 0) == 0) begin
          tx_gap <= $urandom_range(6, 1);
        end
      end
    end
  end

  // Long receiver hold, counted on its own
  always @(negedge clk_i or negedge rst_ni) begin : hold
    if (!rst_ni) begin
      rx_hold_cycles <= 0;
      hold_done      <= 1'b0;
    end else if (!hold_done && accepted >= 300) begin
      rx_hold_cycles <= 40;
      hold_done      <= 1'b1;
    end else if (rx_hold_cycles > 0) begin
      rx_hold_cycles <= rx_hold_cycles - 1;
    end
  end

  // Receiver ready with random idle bursts
  always @(negedge clk_i or negedge rst_ni) begin : rcv
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      rx_gap       <= 0;
    end else if (rx_hold_cycles > 0) begin
      out_if.ready <= 1'b0;
    end else if (rx_gap > 0) begin
      out_if.ready <= 1'b0;
      rx_gap       <= rx_gap - 1;
    end else begin
      out_if.ready <= 1'b1;
      if (!quiet_phase && $urandom_range(3, 0) == 0) begin
        rx_gap <= $urandom_range(6, 1);
      end
    end
  end

  // Monitor: sample both channels on the rising edge
  always @(posedge clk_i or negedge rst_ni) begin : mon
    res_t exp_r;
    res_t got;
    if (!rst_ni) begin
      accepted <= 0;
      received <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got = out_if.data;
        if (expected_q.size() == 0) begin
          if (mismatches < 10) begin
            $display("unexpected result: product %h code %0d", got.product, got.code);
          end
          mismatches++;
        end else begin
          exp_r = expected_q.pop_front();
          if (got !== exp_r) begin
            if (mismatches < 10) begin
              $display("mismatch: expected product %h code %0d, got product %h code %0d",
                       exp_r.product, exp_r.code, got.product, got.code);
            end
            mismatches++;
          end
        end
        received <= received + 1;
      end
      if (in_if.valid && in_if.ready) begin
        expected_q.push_back(fmul_predict(in_if.data[63:32], in_if.data[31:0]));
        accepted <= accepted + 1;
      end
    end
  end

  // Stimulus and sequencing
  initial begin : main
    operands_t op;
    rst_ni = 1'b0;
    // Corner cases first
    pending_q.push_back({32'h3f80_0000, 32'h3f80_0000});
    pending_q.push_back({32'h7f00_0000, 32'h7f00_0000});
    pending_q.push_back({32'h0080_0000, 32'h0080_0000});
    pending_q.push_back({32'h0080_0000, 32'h3f80_0000});
    pending_q.push_back({32'h0080_0000, 32'h3f00_0000});
    pending_q.push_back({32'h7f80_0000, 32'h0000_0000});
    pending_q.push_back({32'h7fc0_0001, 32'h7f80_0000});
    pending_q.push_back({32'hff80_0000, 32'h7f80_0001});
    pending_q.push_back({32'h8000_0000, 32'h3f80_0000});
    pending_q.push_back({32'h3fff_ffff, 32'h3fff_ffff});
    pending_q.push_back({32'hc000_0000, 32'h4000_0000});
    pending_q.push_back({32'h7f7f_ffff, 32'h3f80_0000});
    pending_q.push_back({32'h7f7f_ffff, 32'h3fff_ffff});
    pending_q.push_back({32'h8000_0001, 32'h7f7f_ffff});
    while (pending_q.size() < NumItems) begin
      op.a = rand_operand();
      op.b = rand_operand();
      pending_q.push_back(op);
    end
    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    // Sender pause until the pipeline drains
    wait (issued >= 700);
    hold_sender = 1'b1;
    wait (accepted == issued && expected_q.size() == 0);
    repeat (4) @(posedge clk_i);
    hold_sender = 1'b0;
    // Last part runs without idling
    wait (issued >= 1100);
    quiet_phase = 1'b1;
    wait (received == NumItems);
    repeat (5) @(posedge clk_i);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Run limit
  initial begin
    #1_000_000;
    $display("Mismatches found");
    $finish;
  end
endmodule

@@ sim.f @@
rtl/spm_pkg.sv
rtl/spm_if.sv
rtl/spm_decode.sv
rtl/spm_pack.sv
rtl/single_precision_multiplier.sv
tb/single_precision_multiplier_test.sv
